// ===== rtl/core/khb_pkg.sv =====
// khb_pkg: shared types and constants of the key hash bucket block
// no dependencies; imported by every module of the block
`default_nettype none

package khb_pkg;

   localparam logic [31:0] CRC_POLY       = 32'h82F6_3B78;
   localparam logic [31:0] MIX_MULT       = 32'd2654435761;
   localparam logic [31:0] BUCKET_RESET   = 32'd65536;
   localparam int          MIX_STEPS      = 8;
   localparam int          DIV_STEPS      = 64;

   // shift amounts of the mix; even steps add-shift-left, odd steps xor-shift-right
   localparam logic [4:0] MIX_SHIFT [MIX_STEPS] = '{
      5'd12, 5'd22, 5'd4, 5'd9, 5'd10, 5'd2, 5'd7, 5'd12
   };

   typedef struct packed {
      logic full;
      logic empty;
   } khb_queue_status_type;

endpackage

`default_nettype wire

// ===== rtl/core/khb_crc_front.sv =====
// khb_crc_front: accepts key bytes and folds them into a running crc-32c
// depends on khb_pkg; pushes the finished crc of each key into khb_queue
`default_nettype none

module khb_crc_front
   import khb_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire logic [7:0]           req_key_byte,
   input  wire logic                 req_last_byte,
   input  wire khb_queue_status_type queue_status,
   output logic                      push,
   output logic [31:0]               push_data
);

   logic [31:0] running_crc_ff;
   logic [31:0] running_crc_in;
   logic [31:0] crc_next;
   logic        accept;

   // reflected crc, one byte: eight shift steps
   function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] data);
      logic [31:0] c;
      c = crc ^ {24'b0, data};
      for (int b = 0; b < 8; b++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

   assign req_stall = queue_status.full;
   assign accept    = req_valid && !req_stall;
   assign crc_next  = crc_byte(running_crc_ff, req_key_byte);
   assign push      = accept && req_last_byte;
   assign push_data = crc_next;

   always_comb begin
      running_crc_in = running_crc_ff;
      if (accept) begin
         running_crc_in = req_last_byte ? 32'b0 : crc_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_crc_ff <= 32'b0;
      end else begin
         running_crc_ff <= running_crc_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/khb_queue.sv =====
// khb_queue: small register queue of finished key crcs between front and back
// depends on khb_pkg for the status struct
`default_nettype none

module khb_queue
   import khb_pkg::*;
#(
   parameter int DEPTH = 4
)
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          push,
   input  wire logic [31:0]   push_data,
   input  wire logic          pop,
   output logic [31:0]        pop_data,
   output khb_queue_status_type status
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [31:0]      entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
   endfunction

   assign pop_data     = entry_ff[rd_ptr_ff];
   assign status.full  = (count_ff == CNT_W'(DEPTH));
   assign status.empty = (count_ff == '0);

   always_comb begin
      wr_ptr_in = push ? ptr_inc(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop  ? ptr_inc(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/khb_mix_back.sv =====
// khb_mix_back: mixes each key crc, multiplies and reduces it to a bucket index
// depends on khb_pkg; takes crcs from khb_queue and drives the result channel
`default_nettype none

module khb_mix_back
   import khb_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire khb_queue_status_type queue_status,
   input  wire logic [31:0]          pop_data,
   output logic                      pop,
   input  wire logic [31:0]          bucket_count,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output logic [31:0]               rsp_bucket_index
);

   typedef enum logic [6:0] {
      ST_IDLE   = 7'b0000001,
      ST_MIX    = 7'b0000010,
      ST_MUL_LO = 7'b0000100,
      ST_MUL_HI = 7'b0001000,
      ST_SUM    = 7'b0010000,
      ST_DIV    = 7'b0100000,
      ST_HOLD   = 7'b1000000
   } khb_back_state_type;

   localparam int STEP_W = $clog2(MIX_STEPS);
   localparam int BIT_W  = $clog2(DIV_STEPS);

   khb_back_state_type state_ff, state_in;
   logic [STEP_W-1:0]  step_ff, step_in;
   logic [BIT_W-1:0]   bit_ff, bit_in;
   logic [63:0]        key_ff, key_in;
   logic [63:0]        prod_ff, prod_in;
   logic [31:0]        hi_prod_ff, hi_prod_in;
   logic [63:0]        quo_ff, quo_in;
   logic [32:0]        rem_ff, rem_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [31:0]        rsp_index_ff, rsp_index_in;

   logic [4:0]  shift;
   logic [63:0] mixed;
   logic [31:0] mul_a;
   logic [63:0] mul_p;
   logic [63:0] hash;
   logic [32:0] rem_shift;
   logic [33:0] rem_diff;
   logic        out_free;

   assign shift = MIX_SHIFT[step_ff];
   assign mixed = step_ff[0] ? (key_ff ^ (key_ff >> shift)) : (key_ff + (key_ff << shift));

   // (k >> 3) split into low 32 and high 29 bits; one shared 32x32 multiplier
   assign mul_a = (state_ff == ST_MUL_LO) ? key_ff[34:3] : {3'b0, key_ff[63:35]};
   assign mul_p = 64'(mul_a) * 64'(MIX_MULT);
   assign hash  = prod_ff + {hi_prod_ff, 32'b0};

   // restoring division, one quotient bit per cycle
   assign rem_shift = {rem_ff[31:0], quo_ff[63]};
   assign rem_diff  = {1'b0, rem_shift} - {2'b0, bucket_count};

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign pop      = (state_ff == ST_IDLE) && !queue_status.empty;

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      bit_in       = bit_ff;
      key_in       = key_ff;
      prod_in      = prod_ff;
      hi_prod_in   = hi_prod_ff;
      quo_in       = quo_ff;
      rem_in       = rem_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_index_in = rsp_index_ff;
      case (state_ff)
         ST_IDLE: begin
            if (pop) begin
               key_in   = {32'b0, pop_data};
               step_in  = '0;
               state_in = ST_MIX;
            end
         end
         ST_MIX: begin
            key_in  = mixed;
            step_in = step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(MIX_STEPS - 1)) begin
               state_in = ST_MUL_LO;
            end
         end
         ST_MUL_LO: begin
            prod_in  = mul_p;
            state_in = ST_MUL_HI;
         end
         ST_MUL_HI: begin
            hi_prod_in = mul_p[31:0];
            state_in   = ST_SUM;
         end
         ST_SUM: begin
            quo_in = hash;
            bit_in = '0;
            if (bucket_count == 32'b0) begin
               // zero bucket count: low 32 bits of the hash pass through
               rem_in   = {1'b0, hash[31:0]};
               state_in = ST_HOLD;
            end else begin
               rem_in   = '0;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            quo_in = {quo_ff[62:0], 1'b0};
            rem_in = rem_diff[33] ? rem_shift : rem_diff[32:0];
            bit_in = bit_ff + BIT_W'(1);
            if (bit_ff == BIT_W'(DIV_STEPS - 1)) begin
               state_in = ST_HOLD;
            end
         end
         ST_HOLD: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_index_in = rem_ff[31:0];
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      step_ff      <= step_in;
      bit_ff       <= bit_in;
      key_ff       <= key_in;
      prod_ff      <= prod_in;
      hi_prod_ff   <= hi_prod_in;
      quo_ff       <= quo_in;
      rem_ff       <= rem_in;
      rsp_index_ff <= rsp_index_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_bucket_index = rsp_index_ff;

endmodule

`default_nettype wire

// ===== rtl/core/key_hash_bucket.sv =====
// key_hash_bucket: maps keys, streamed one byte per cycle unless stalled, to hash
// table buckets. The front takes one key byte every cycle into a crc-32c while
// the queue is not full; a key's crc then waits in a QUEUE_DEPTH entry queue
// until the back is free. The back pops the crc, runs 8 mix steps, multiplies on
// one shared 32x32 multiplier, sums, runs a bit-serial modulo by bucket_count and
// loads the result register; with a bucket count of zero the modulo is skipped,
// giving the low 32 bits of the mixed hash. A stalled result holds the back in
// place. Keys long enough for the back to keep pace stream with no stall while
// the result side keeps up; shorter keys fill the queue and stall the input.
// bucket_count (reset 65536) is written through csr_wr_en/csr_wr_data; the user
// must write it only while the block is idle, which the block does not enforce.
`default_nettype none

module key_hash_bucket
   import khb_pkg::*;
#(
   parameter int QUEUE_DEPTH = 4
)
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_key_byte,
   input  wire logic        req_last_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [31:0]      rsp_bucket_index,
   input  wire logic        csr_wr_en,
   input  wire logic [31:0] csr_wr_data
);

   logic [31:0]          bucket_count_ff;
   logic [31:0]          bucket_count_in;
   khb_queue_status_type queue_status;
   logic                 push;
   logic [31:0]          push_data;
   logic                 pop;
   logic [31:0]          pop_data;

   assign bucket_count_in = csr_wr_en ? csr_wr_data : bucket_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         bucket_count_ff <= BUCKET_RESET;
      end else begin
         bucket_count_ff <= bucket_count_in;
      end
   end

   khb_crc_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_key_byte  (req_key_byte),
      .req_last_byte (req_last_byte),
      .queue_status  (queue_status),
      .push          (push),
      .push_data     (push_data)
   );

   khb_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .status    (queue_status)
   );

   khb_mix_back u_back (
      .clock            (clock),
      .reset            (reset),
      .queue_status     (queue_status),
      .pop_data         (pop_data),
      .pop              (pop),
      .bucket_count     (bucket_count_ff),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_bucket_index (rsp_bucket_index)
   );

endmodule

`default_nettype wire
